@@ design/chbd_pkg.sv @@
// Shared types, constants and decode helpers for the chunked body deframer.
package chbd_pkg;

    localparam int SIZE_LINE_LIMIT = 9;
    localparam int COUNT_WIDTH     = 32;
    localparam int LINE_W          = $clog2(SIZE_LINE_LIMIT + 1);
    localparam int BODY_COUNT_W    = 32;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_INDEX_W     = 1;

    typedef logic [COUNT_WIDTH-1:0]  count_t;
    typedef logic [LINE_W-1:0]       line_len_t;
    typedef logic [BODY_COUNT_W-1:0] body_count_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CHUNKED_MODE = 1'b0,
        CFG_BODY_LENGTH  = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_PAYLOAD  = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_ERROR    = 2'd2
    } status_t;

    typedef enum logic {
        KIND_BYTE  = 1'b0,
        KIND_START = 1'b1
    } kind_t;

    localparam logic [7:0] CHAR_CR = 8'h0D;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66)
            || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 4'(c - 8'h37);
        end
        return v;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C;
    endfunction

endpackage

@@ design/chbd_in_if.sv @@
// Input channel: start markers and raw body bytes.
interface chbd_in_if;
    import chbd_pkg::*;

    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

@@ design/chbd_out_if.sv @@
// Output channel: payload bytes, completion and framing error beats.
interface chbd_out_if;
    import chbd_pkg::*;

    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [1:0]  status;
    body_count_t body_count;

    modport source (output valid, output out_byte, output status, output body_count,
                    input ready);
    modport sink   (input valid, input out_byte, input status, input body_count,
                    output ready);
endinterface

@@ design/http_chunked_body_deframer.sv @@
// Path: an input beat is captured in the input register when taken, then
// processed into the result register once that register is free or draining.
// Throughput: one input beat per cycle while the result side is not stalled; the result register holds one beat
// while the next input beat is taken and processed once the result drains.
// Reset: rst_n asynchronous, active low; clears both registers, config and
// the parser to idle with no body active.
module http_chunked_body_deframer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [chbd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [chbd_pkg::CFG_DATA_W-1:0]   cfg_data,
    chbd_in_if.sink                           body,
    chbd_out_if.source                        result
);
    import chbd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SIZE,
        PH_LF,
        PH_DATA,
        PH_TRAIL,
        PH_DRAIN,
        PH_LEN,
        PH_ERR
    } phase_t;

    // Configuration, sampled at the start marker.
    logic        chunked_mode_reg;
    logic [31:0] body_length_reg;

    // Input register.
    logic        s1_valid_reg;
    logic        s1_kind_reg;
    logic [7:0]  s1_byte_reg;

    // Parser state.
    phase_t      phase_reg, phase_next;
    count_t      size_acc_reg, size_acc_next;
    logic        digits_seen_reg, digits_seen_next;
    logic        digits_ended_reg, digits_ended_next;
    line_len_t   line_len_reg, line_len_next;
    count_t      remaining_reg, remaining_next;
    count_t      delivered_reg, delivered_next;
    logic [1:0]  skip_reg, skip_next;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    status_t     out_status_reg, out_status_next;
    body_count_t out_count_reg, out_count_next;

    logic        advance;
    logic        take;
    line_len_t   line_inc;
    count_t      remaining_dec;

    // Process the held beat once the result register is free or draining.
    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign body.ready = !s1_valid_reg || advance;
    assign take       = body.valid && body.ready;

    assign line_inc      = line_len_reg + line_len_t'(1);
    assign remaining_dec = remaining_reg - count_t'(1);

    always_comb
    begin
        phase_next        = phase_reg;
        size_acc_next     = size_acc_reg;
        digits_seen_next  = digits_seen_reg;
        digits_ended_next = digits_ended_reg;
        line_len_next     = line_len_reg;
        remaining_next    = remaining_reg;
        delivered_next    = delivered_reg;
        skip_next         = skip_reg;
        out_valid_next    = out_valid_reg && !result.ready;
        out_byte_next     = out_byte_reg;
        out_status_next   = out_status_reg;
        out_count_next    = out_count_reg;

        if (advance)
        begin
            out_valid_next  = 1'b0;
            out_byte_next   = 8'd0;
            out_status_next = ST_PAYLOAD;

            if (s1_kind_reg == KIND_START)
            begin
                // Abandon any body in flight and restart.
                size_acc_next     = '0;
                digits_seen_next  = 1'b0;
                digits_ended_next = 1'b0;
                line_len_next     = '0;
                delivered_next    = '0;
                skip_next         = 2'd0;
                remaining_next    = '0;
                if (chunked_mode_reg)
                begin
                    phase_next = PH_SIZE;
                end
                else if (body_length_reg == 32'd0)
                begin
                    // Empty fixed length body completes on the marker itself.
                    phase_next      = PH_IDLE;
                    out_valid_next  = 1'b1;
                    out_status_next = ST_COMPLETE;
                end
                else
                begin
                    remaining_next = count_t'(body_length_reg);
                    phase_next     = PH_LEN;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_SIZE:
                    begin
                        if (s1_byte_reg == CHAR_CR)
                        begin
                            phase_next = PH_LF;
                        end
                        else
                        begin
                            line_len_next = line_inc;
                            if (line_inc >= line_len_t'(SIZE_LINE_LIMIT))
                            begin
                                phase_next      = PH_ERR;
                                out_valid_next  = 1'b1;
                                out_status_next = ST_ERROR;
                            end
                            else if (!digits_ended_reg)
                            begin
                                if (is_hex(s1_byte_reg))
                                begin
                                    // Error on a digit that would overflow the size.
                                    if (size_acc_reg[COUNT_WIDTH-1 -: 4] != 4'd0)
                                    begin
                                        phase_next      = PH_ERR;
                                        out_valid_next  = 1'b1;
                                        out_status_next = ST_ERROR;
                                    end
                                    else
                                    begin
                                        size_acc_next = {size_acc_reg[COUNT_WIDTH-5:0],
                                                         hex_value(s1_byte_reg)};
                                        digits_seen_next = 1'b1;
                                    end
                                end
                                else if (!(is_blank(s1_byte_reg) && !digits_seen_reg))
                                begin
                                    digits_ended_next = 1'b1;
                                end
                            end
                        end
                    end
                    PH_LF:
                    begin
                        // The byte after CR is dropped unchecked.
                        if (size_acc_reg == '0)
                        begin
                            skip_next  = 2'd2;
                            phase_next = PH_DRAIN;
                        end
                        else if (size_acc_reg > ~delivered_reg)
                        begin
                            // Total would overflow the count.
                            phase_next      = PH_ERR;
                            out_valid_next  = 1'b1;
                            out_status_next = ST_ERROR;
                        end
                        else
                        begin
                            remaining_next = size_acc_reg;
                            phase_next     = PH_DATA;
                        end
                    end
                    PH_DATA, PH_LEN:
                    begin
                        delivered_next = delivered_reg + count_t'(1);
                        remaining_next = remaining_dec;
                        out_valid_next = 1'b1;
                        out_byte_next  = s1_byte_reg;
                        if (remaining_dec == '0)
                        begin
                            if (phase_reg == PH_DATA)
                            begin
                                skip_next  = 2'd2;
                                phase_next = PH_TRAIL;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    PH_TRAIL:
                    begin
                        skip_next = skip_reg - 2'd1;
                        if (skip_reg == 2'd1)
                        begin
                            size_acc_next     = '0;
                            digits_seen_next  = 1'b0;
                            digits_ended_next = 1'b0;
                            line_len_next     = '0;
                            phase_next        = PH_SIZE;
                        end
                    end
                    PH_DRAIN:
                    begin
                        skip_next = skip_reg - 2'd1;
                        if (skip_reg == 2'd1)
                        begin
                            phase_next      = PH_IDLE;
                            out_valid_next  = 1'b1;
                            out_status_next = ST_COMPLETE;
                        end
                    end
                    PH_IDLE, PH_ERR:
                    begin
                        // Ignore bytes outside a body.
                    end
                    default:
                    begin
                    end
                endcase
            end

            out_count_next = body_count_t'(delivered_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunked_mode_reg <= 1'b0;
            body_length_reg  <= 32'd0;
            s1_valid_reg     <= 1'b0;
            s1_kind_reg      <= 1'b0;
            s1_byte_reg      <= 8'd0;
            phase_reg        <= PH_IDLE;
            size_acc_reg     <= '0;
            digits_seen_reg  <= 1'b0;
            digits_ended_reg <= 1'b0;
            line_len_reg     <= '0;
            remaining_reg    <= '0;
            delivered_reg    <= '0;
            skip_reg         <= 2'd0;
            out_valid_reg    <= 1'b0;
            out_byte_reg     <= 8'd0;
            out_status_reg   <= ST_PAYLOAD;
            out_count_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_CHUNKED_MODE: chunked_mode_reg <= cfg_data[0];
                    CFG_BODY_LENGTH:  body_length_reg  <= cfg_data[31:0];
                    default:
                    begin
                    end
                endcase
            end

            // Hold the input beat until it is processed.
            if (take)
            begin
                s1_valid_reg <= 1'b1;
                s1_kind_reg  <= body.kind;
                s1_byte_reg  <= body.data_byte;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            phase_reg        <= phase_next;
            size_acc_reg     <= size_acc_next;
            digits_seen_reg  <= digits_seen_next;
            digits_ended_reg <= digits_ended_next;
            line_len_reg     <= line_len_next;
            remaining_reg    <= remaining_next;
            delivered_reg    <= delivered_next;
            skip_reg         <= skip_next;
            out_valid_reg    <= out_valid_next;
            out_byte_reg     <= out_byte_next;
            out_status_reg   <= out_status_next;
            out_count_reg    <= out_count_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.out_byte   = out_byte_reg;
    assign result.status     = out_status_reg;
    assign result.body_count = out_count_reg;

endmodule

@@ tb/http_chunked_body_deframer_checker.sv @@
// Scoreboard for the chunked body deframer: predicts result beats and compares them.
`timescale 1ns / 100ps

module http_chunked_body_deframer_checker
    import chbd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    chbd_in_if                     body,
    chbd_out_if                    result,
    output int                     failures,
    output int                     pending
);

    typedef enum logic [2:0] {
        PS_IDLE,
        PS_SIZE_LINE,
        PS_AFTER_CR,
        PS_DATA,
        PS_TRAILER,
        PS_DRAIN,
        PS_FIXED,
        PS_HALTED
    } parse_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        status_t     status;
        body_count_t body_count;
    } body_beat_t;

    body_beat_t  expected_beats[$];

    // register copies, updated on each write; the parser reads them only at a start marker
    logic        chunked_cfg;
    count_t      length_cfg;

    parse_t      state;
    count_t      size_acc;
    logic        saw_digit;
    logic        digits_done;
    int          line_len;
    count_t      remaining;
    count_t      delivered;
    logic [1:0]  skip;

    task automatic push_beat(input logic [7:0] b, input status_t st);
        body_beat_t beat;
        beat.out_byte   = (st == ST_PAYLOAD) ? b : 8'h00;
        beat.status     = st;
        beat.body_count = body_count_t'(delivered);
        expected_beats.push_back(beat);
    endtask

    task automatic halt();
        state = PS_HALTED;
        push_beat(8'h00, ST_ERROR);
    endtask

    task automatic clear_line();
        size_acc    = '0;
        saw_digit   = 1'b0;
        digits_done = 1'b0;
        line_len    = 0;
    endtask

    task automatic flag(input string field, input logic [63:0] want, input logic [63:0] got);
        failures++;
        $error("%s: expected %0h, got %0h", field, want, got);
    endtask

    // Fold letters to lower case; digits keep their low nibble, a..f map to 10..15.
    task automatic decode_hex(input logic [7:0] c, output logic ok, output logic [3:0] nib);
        logic [7:0] folded;
        folded = c | 8'h20;
        ok     = 1'b1;
        nib    = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            nib = c[3:0];
        end
        else if (folded >= 8'h61 && folded <= 8'h66)
        begin
            nib = 4'(folded[3:0] + 4'd9);
        end
        else
        begin
            ok = 1'b0;
        end
    endtask

    task automatic deframe(input logic is_start, input logic [7:0] c);
        logic       ok;
        logic [3:0] nib;
        if (is_start)
        begin
            clear_line();
            delivered = '0;
            remaining = '0;
            skip      = 2'd0;
            if (chunked_cfg)
            begin
                state = PS_SIZE_LINE;
            end
            else if (length_cfg == 0)
            begin
                state = PS_IDLE;
                push_beat(8'h00, ST_COMPLETE);
            end
            else
            begin
                remaining = length_cfg;
                state     = PS_FIXED;
            end
            return;
        end
        case (state)
            PS_SIZE_LINE:
            begin
                if (c == CHAR_CR)
                begin
                    state = PS_AFTER_CR;
                end
                else
                begin
                    line_len++;
                    if (line_len >= SIZE_LINE_LIMIT)
                    begin
                        halt();
                    end
                    else if (!digits_done)
                    begin
                        decode_hex(c, ok, nib);
                        if (ok)
                        begin
                            if (size_acc[COUNT_WIDTH-1 -: 4] != 4'd0)
                            begin
                                halt();
                            end
                            else
                            begin
                                size_acc  = {size_acc[COUNT_WIDTH-5:0], nib};
                                saw_digit = 1'b1;
                            end
                        end
                        else if (saw_digit || !(c inside {8'h20, 8'h09, [8'h0A:8'h0C]}))
                        begin
                            digits_done = 1'b1;
                        end
                    end
                end
            end
            PS_AFTER_CR:
            begin
                if (size_acc == 0)
                begin
                    skip  = 2'd2;
                    state = PS_DRAIN;
                end
                else if (size_acc > ~delivered)
                begin
                    halt();
                end
                else
                begin
                    remaining = size_acc;
                    state     = PS_DATA;
                end
            end
            PS_DATA:
            begin
                delivered++;
                remaining--;
                if (remaining == 0)
                begin
                    skip  = 2'd2;
                    state = PS_TRAILER;
                end
                push_beat(c, ST_PAYLOAD);
            end
            PS_TRAILER:
            begin
                skip--;
                if (skip == 0)
                begin
                    clear_line();
                    state = PS_SIZE_LINE;
                end
            end
            PS_DRAIN:
            begin
                skip--;
                if (skip == 0)
                begin
                    state = PS_IDLE;
                    push_beat(8'h00, ST_COMPLETE);
                end
            end
            PS_FIXED:
            begin
                delivered++;
                remaining--;
                if (remaining == 0)
                begin
                    state = PS_IDLE;
                end
                push_beat(c, ST_PAYLOAD);
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        body_beat_t want;
        if (!rst_n)
        begin
            chunked_cfg = 1'b0;
            length_cfg  = '0;
            state       = PS_IDLE;
            clear_line();
            remaining   = '0;
            delivered   = '0;
            skip        = 2'd0;
            expected_beats.delete();
            failures    = 0;
            pending     = 0;
        end
        else
        begin
            // results first: a beat taken at this edge cannot answer input taken now
            if (result.valid && result.ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    failures++;
                    $error("result beat with nothing expected: status %0d, body_count %0d",
                           result.status, result.body_count);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (result.out_byte !== want.out_byte)
                    begin
                        flag("out_byte", want.out_byte, result.out_byte);
                    end
                    if (result.status !== want.status)
                    begin
                        flag("status", want.status, result.status);
                    end
                    if (result.body_count !== want.body_count)
                    begin
                        flag("body_count", want.body_count, result.body_count);
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_CHUNKED_MODE)
                begin
                    chunked_cfg = cfg_data[0];
                end
                else
                begin
                    length_cfg = count_t'(cfg_data);
                end
            end
            if (body.valid && body.ready)
            begin
                deframe(body.kind == KIND_START, body.data_byte);
            end
            pending = expected_beats.size();
        end
    end

endmodule

@@ tb/http_chunked_body_deframer_tb.sv @@
// Top of the deframer testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 100ps

module http_chunked_body_deframer_tb;
    import chbd_pkg::*;

    // Kinds of broken chunked bodies mixed into the random part.
    typedef enum int {
        FAULT_NONE,
        FAULT_LONG_LINE,
        FAULT_OVERFLOW,
        FAULT_CUT_CHUNK,
        FAULT_HUGE_CHUNK
    } fault_t;

    // Generous bound; a correct run with every stall phase needs far less.
    localparam int CYCLE_LIMIT = 400000;
    // Longest size line that still parses: one short of the line limit.
    localparam int LINE_ROOM   = SIZE_LINE_LIMIT - 1;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int                     failures;
    int                     pending;
    int                     items_sent = 0;
    int                     src_idle_pct = 0;
    int                     sink_stall_pct = 0;
    int unsigned            cycle_count = 0;

    // Shadow of what was last programmed, so stimulus can shape bodies to fit.
    logic                   cur_mode;
    count_t                 cur_len;

    logic [7:0]             blanks [5] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C};

    chbd_in_if  body_if ();
    chbd_out_if result_if ();

    http_chunked_body_deframer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .body      (body_if),
        .result    (result_if)
    );

    http_chunked_body_deframer_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .body      (body_if),
        .result    (result_if),
        .failures  (failures),
        .pending   (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stall the result side at the rate of the current phase; decide at the
    // falling edge so the block sees a settled ready at the next rising edge.
    always @(negedge clk)
    begin
        result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Hard stop in case a beat never comes back.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Present one beat and hold it until taken. Entered and left at a falling
    // edge. Valid stays high across back-to-back beats; it only drops when a
    // gap is inserted, so it never gets two updates in one step.
    task automatic send_beat(input kind_t k, input logic [7:0] b, input bit live);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            body_if.valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        body_if.valid     <= 1'b1;
        body_if.kind      <= k;
        body_if.data_byte <= b;
        do @(posedge clk); while (!body_if.ready);
        @(negedge clk);
        if (live)
        begin
            items_sent++;
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat(KIND_BYTE, b, 1'b1);
    endtask

    // Bytes the block drops while idle or after an error; they don't count.
    task automatic send_noise();
        repeat ($urandom_range(2)) send_beat(KIND_BYTE, 8'($urandom_range(255)), 1'b0);
    endtask

    // Drop valid and wait out every outstanding result, plus the pipeline
    // depth for beats that produce nothing.
    task automatic settle();
        body_if.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (4) @(negedge clk);
    endtask

    // Write both registers on consecutive cycles; only call when settled.
    task automatic program_regs(input logic mode, input count_t len);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CHUNKED_MODE;
        cfg_data  <= CFG_DATA_W'(mode);
        @(negedge clk);
        cfg_index <= CFG_BODY_LENGTH;
        cfg_data  <= CFG_DATA_W'(len);
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_mode  = mode;
        cur_len   = len;
    endtask

    function automatic logic [7:0] any_but_cr();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (c == CHAR_CR);
        return c;
    endfunction

    // A byte that ends the digit run: not hex, not blank, not CR.
    function automatic logic [7:0] digit_stopper();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (is_hex(c) || is_blank(c) || c == CHAR_CR);
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return 8'(8'h30 + n);
        end
        return 8'(($urandom_range(1) ? 8'h61 : 8'h41) + n - 10);
    endfunction

    // Emit a size line that fits the limit: optional leading blanks, optional
    // leading zeros, the digits in random case, an optional extension, CR and
    // the byte after it (usually LF). With bare set and size zero, send no
    // digit at all.
    task automatic send_size_line(input count_t size, input bit bare);
        int     nd;
        int     room;
        int     lead;
        int     zeros;
        int     ext;
        count_t s;
        nd = 0;
        s  = size;
        while (s != 0)
        begin
            nd++;
            s = s >> 4;
        end
        if (nd == 0 && !bare)
        begin
            nd = 1;
        end
        room  = LINE_ROOM - nd;
        lead  = 0;
        zeros = 0;
        ext   = 0;
        if (room > 0 && $urandom_range(3) == 0)
        begin
            lead = $urandom_range(1, (room > 2) ? 2 : room);
        end
        room -= lead;
        if (room > 0 && $urandom_range(5) == 0)
        begin
            zeros = $urandom_range(1, room);
        end
        room -= zeros;
        if (room > 0 && $urandom_range(4) == 0)
        begin
            ext = $urandom_range(1, room);
        end
        repeat (lead) send_byte(blanks[$urandom_range(4)]);
        repeat (zeros) send_byte(8'h30);
        for (int i = nd - 1; i >= 0; i--)
        begin
            send_byte(hex_char(size[4*i +: 4]));
        end
        if (ext > 0)
        begin
            send_byte(digit_stopper());
            repeat (ext - 1) send_byte(any_but_cr());
        end
        send_byte(CHAR_CR);
        send_byte(($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'h0A);
    endtask

    // Two bytes the block skips unchecked: mostly CR LF, sometimes junk.
    task automatic send_skip_pair();
        if ($urandom_range(5) == 0)
        begin
            repeat (2) send_byte(8'($urandom_range(255)));
        end
        else
        begin
            send_byte(CHAR_CR);
            send_byte(8'h0A);
        end
    endtask

    // One chunked body: start, up to three chunks, then either the zero-size
    // line and drain, or one of the fault shapes.
    task automatic chunked_body();
        fault_t fault;
        int     chunks;
        int     len;
        int     total;
        send_beat(KIND_START, 8'($urandom_range(255)), 1'b1);
        fault = FAULT_NONE;
        if ($urandom_range(99) < 15)
        begin
            fault = fault_t'($urandom_range(FAULT_LONG_LINE, FAULT_HUGE_CHUNK));
        end
        chunks = $urandom_range(3);
        if (fault == FAULT_OVERFLOW && chunks == 0)
        begin
            chunks = 1;
        end
        if (fault == FAULT_HUGE_CHUNK)
        begin
            chunks = 0;
        end
        total = 0;
        repeat (chunks)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            total += len;
            send_size_line(count_t'(len), 1'b0);
            repeat (len) send_byte(8'($urandom_range(255)));
            send_skip_pair();
        end
        case (fault)
            FAULT_NONE:
            begin
                send_size_line('0, $urandom_range(3) == 0);
                send_skip_pair();
                send_noise();
            end
            FAULT_LONG_LINE:
            begin
                repeat ($urandom_range(SIZE_LINE_LIMIT, SIZE_LINE_LIMIT + 3))
                    send_byte(any_but_cr());
                send_noise();
            end
            FAULT_OVERFLOW:
            begin
                // any size above the headroom left by the bytes already delivered
                send_size_line('1 - count_t'($urandom_range(total - 1)), 1'b0);
                send_noise();
            end
            FAULT_CUT_CHUNK:
            begin
                // leave the chunk short; the next start marker abandons it
                len = $urandom_range(1, 12);
                send_size_line(count_t'(len), 1'b0);
                repeat ($urandom_range(len - 1)) send_byte(8'($urandom_range(255)));
            end
            default:
            begin
                // first chunk of at least 0x0100_0000 bytes, then abandon
                send_size_line(count_t'($urandom()) | count_t'(32'h0100_0000), 1'b0);
                repeat ($urandom_range(5)) send_byte(8'($urandom_range(255)));
            end
        endcase
    endtask

    // One fixed length body at the programmed length; huge lengths and a few
    // short ones are cut off and left for the next start marker.
    task automatic fixed_body();
        int n;
        send_beat(KIND_START, 8'($urandom_range(255)), 1'b1);
        if (cur_len == 0)
        begin
            send_noise();
            return;
        end
        if (cur_len > 64)
        begin
            n = $urandom_range(6);
        end
        else if ($urandom_range(9) == 0)
        begin
            n = $urandom_range(cur_len - 1);
        end
        else
        begin
            n = cur_len;
        end
        repeat (n) send_byte(8'($urandom_range(255)));
        if (n == cur_len)
        begin
            send_noise();
        end
    endtask

    // Pick a new setting, mostly chunked, with lengths at both extremes now
    // and then; wait for the block to go quiet before writing.
    task automatic reprogram();
        logic   mode;
        count_t len;
        mode = ($urandom_range(4) < 3) ? 1'b1 : 1'b0;
        case ($urandom_range(9))
            0:       len = '0;
            1:       len = '1;
            2:       len = count_t'($urandom());
            default: len = count_t'($urandom_range(1, 40));
        endcase
        settle();
        program_regs(mode, len);
    endtask

    initial
    begin
        // one-chunk body: form feed before the digits, a leading zero, junk
        // after CR, then "0x5" which reads as size zero
        logic [7:0] chunk_script [16] = '{8'h0C, 8'h30, 8'h32, 8'h0D, 8'hFF,
                                         8'h00, 8'hFF, 8'h0D, 8'h0A,
                                         8'h30, 8'h78, 8'h35, 8'h0D, 8'h0A,
                                         8'h0D, 8'h0A};
        // nine characters without CR: "1aF ;zzzz" overruns the line limit
        logic [7:0] long_script [9]   = '{8'h31, 8'h61, 8'h46, 8'h20, 8'h3B,
                                         8'h7A, 8'h7A, 8'h7A, 8'h7A};
        int         idle_plan [4]     = '{0, 53, 0, 27};
        int         stall_plan [4]    = '{0, 0, 53, 27};
        int         target;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_CHUNKED_MODE;
        cfg_data            = '0;
        body_if.valid       = 1'b0;
        body_if.kind        = KIND_BYTE;
        body_if.data_byte   = 8'h00;
        result_if.ready     = 1'b0;
        cur_mode            = 1'b0;
        cur_len             = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero fixed length completes on the start marker alone.
        program_regs(1'b0, '0);
        send_beat(KIND_START, 8'hFF, 1'b1);
        settle();

        // Largest fixed length: pass two extreme bytes, then abandon the body.
        program_regs(1'b0, '1);
        send_beat(KIND_START, 8'h00, 1'b1);
        send_byte(8'h00);
        send_byte(8'hFF);
        settle();

        // Switch to chunked while that body is still open; the next start
        // marker drops it and picks up the new mode.
        program_regs(1'b1, count_t'(5));
        send_beat(KIND_START, 8'h00, 1'b1);
        foreach (chunk_script[i])
        begin
            send_byte(chunk_script[i]);
        end
        send_beat(KIND_START, 8'h5A, 1'b1);
        foreach (long_script[i])
        begin
            send_byte(long_script[i]);
        end
        // after the error, bytes are dropped until the next start
        send_beat(KIND_BYTE, 8'h31, 1'b0);

        // Random: four idle patterns, each with a fresh share of the beats.
        for (int p = 0; p < 4; p++)
        begin
            settle();
            src_idle_pct   = idle_plan[p];
            sink_stall_pct = stall_plan[p];
            target         = items_sent + 255;
            reprogram();
            while (items_sent < target)
            begin
                if ($urandom_range(3) == 0)
                begin
                    reprogram();
                end
                if (cur_mode)
                begin
                    chunked_body();
                end
                else
                begin
                    fixed_body();
                end
            end
        end

        // Drain everything and let a stray late beat show up before judging.
        settle();
        repeat (4) @(negedge clk);
        if (failures == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/chbd_pkg.sv
design/chbd_in_if.sv
design/chbd_out_if.sv
design/http_chunked_body_deframer.sv
tb/http_chunked_body_deframer_checker.sv
tb/http_chunked_body_deframer_tb.sv
